>>> design/jsu_pkg.sv
package jsu_pkg;

  // saturating width of the decoded length counter
  localparam int unsigned LenBits = 16;
  // width of the string_length field shown on the result channel
  localparam int unsigned OutLenW = 16;
  // depth of the command queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_CTRL = 3'd1,
    ERR_ESC  = 3'd2,
    ERR_SURR = 3'd3,
    ERR_UTF8 = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    CMD_BYTE, // one raw byte, passed as is
    CMD_CODE, // code point, utf-8 encoded by the back
    CMD_END   // string end, by quote or error
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [20:0] value;
    err_e        err;
    logic        restart; // length counter restarts with this command
  } cmd_t;

endpackage

>>> design/jsu_ifs.sv
interface jsu_in_if import jsu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [31:0]        out_bytes;
  logic [2:0]         out_count;
  logic               last;
  logic [2:0]         err_code;
  logic [OutLenW-1:0] string_length;

  modport source (output valid, output out_bytes, output out_count, output last,
                  output err_code, output string_length, input ready);
  modport sink   (input valid, input out_bytes, input out_count, input last,
                  input err_code, input string_length, output ready);
endinterface

interface jsu_cfg_if import jsu_pkg::*; ();
  logic valid;
  logic ready;
  logic check_utf8;

  modport source (output valid, output check_utf8, input ready);
  modport sink   (input valid, input check_utf8, output ready);
endinterface

>>> design/jsu_front.sv
module jsu_front import jsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsu_in_if.sink      in_i,
  jsu_cfg_if.sink     cfg_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    MODE_NORMAL, MODE_ESC, MODE_HEX, MODE_SUR_BSL, MODE_SUR_U, MODE_SUR_HEX
  } mode_e;

  typedef enum logic [2:0] {
    CLS_ANY, CLS_A0_BF, CLS_80_9F, CLS_90_BF, CLS_80_8F
  } cls_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;

  mode_e       mode_q, mode_d, mode_e_v;
  cls_e        cls_q, cls_d, cls_e_v;
  logic [1:0]  cnt_q, cnt_d, cnt_e;
  logic [15:0] acc_q, acc_d, acc_e;
  logic [9:0]  hi_q, hi_d, hi_e;
  logic [1:0]  rem_q, rem_d, rem_e;
  logic        halted_q, halted_d, halted_e;
  logic        restart_q, restart_d, restart_e;
  logic        check_q;

  logic [7:0]  c;
  logic        fire;
  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [15:0] acc_new;
  logic        cls_ok;
  logic        push;

  assign c        = in_i.data_byte;
  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign fire     = in_i.valid && !full_i;
  assign push_o   = fire && push;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_nib = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    unique case (cls_e_v)
      CLS_A0_BF: cls_ok = c >= 8'hA0 && c <= 8'hBF;
      CLS_80_9F: cls_ok = c >= 8'h80 && c <= 8'h9F;
      CLS_90_BF: cls_ok = c >= 8'h90 && c <= 8'hBF;
      CLS_80_8F: cls_ok = c >= 8'h80 && c <= 8'h8F;
      default:   cls_ok = c >= 8'h80 && c <= 8'hBF;
    endcase
  end

  assign acc_new = {acc_e[11:0], hex_nib};

  always_comb begin
    // a first byte clears all string state before it is looked at
    if (in_i.first_byte) begin
      mode_e_v = MODE_NORMAL; cls_e_v = CLS_ANY; cnt_e = '0; acc_e = '0;
      hi_e = '0; rem_e = '0; halted_e = 1'b0; restart_e = 1'b1;
    end else begin
      mode_e_v = mode_q; cls_e_v = cls_q; cnt_e = cnt_q; acc_e = acc_q;
      hi_e = hi_q; rem_e = rem_q; halted_e = halted_q; restart_e = restart_q;
    end

    mode_d = mode_e_v; cls_d = cls_e_v; cnt_d = cnt_e; acc_d = acc_e;
    hi_d = hi_e; rem_d = rem_e; halted_d = halted_e;
    push = 1'b0;
    cmd_o.kind    = CMD_BYTE;
    cmd_o.value   = {13'd0, c};
    cmd_o.err     = ERR_NONE;
    cmd_o.restart = restart_e;

    if (!halted_e) begin
      unique case (mode_e_v)
        MODE_ESC: begin
          mode_d = MODE_NORMAL;
          push   = 1'b1;
          unique case (c)
            ChQuote: cmd_o.value = 21'h22;
            ChSlash: cmd_o.value = 21'h2F;
            ChBsl:   cmd_o.value = 21'h5C;
            ChB:     cmd_o.value = 21'h08;
            ChF:     cmd_o.value = 21'h0C;
            ChN:     cmd_o.value = 21'h0A;
            ChR:     cmd_o.value = 21'h0D;
            ChT:     cmd_o.value = 21'h09;
            ChU: begin
              mode_d = MODE_HEX;
              cnt_d  = '0;
              acc_d  = '0;
              push   = 1'b0;
            end
            default: begin
              mode_d    = mode_e_v;
              cmd_o.kind = CMD_END;
              cmd_o.err  = ERR_ESC;
              halted_d   = 1'b1;
            end
          endcase
        end
        MODE_HEX, MODE_SUR_HEX: begin
          if (!hex_ok) begin
            push = 1'b1; cmd_o.kind = CMD_END; cmd_o.err = ERR_ESC; halted_d = 1'b1;
          end else begin
            acc_d = acc_new;
            if (cnt_e != 2'd3) begin
              cnt_d = cnt_e + 2'd1;
            end else begin
              cnt_d = '0;
              if (mode_e_v == MODE_SUR_HEX) begin
                push = 1'b1;
                if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                  cmd_o.kind = CMD_END; cmd_o.err = ERR_SURR; halted_d = 1'b1;
                end else begin
                  // join the pair: 0x10000 + (high << 10 | low)
                  mode_d      = MODE_NORMAL;
                  cmd_o.kind  = CMD_CODE;
                  cmd_o.value = {1'b0, hi_e, acc_new[9:0]} + 21'h10000;
                end
              end else if (acc_new >= 16'hD800 && acc_new <= 16'hDFFF) begin
                if (acc_new > 16'hDBFF) begin
                  push = 1'b1; cmd_o.kind = CMD_END; cmd_o.err = ERR_SURR; halted_d = 1'b1;
                end else begin
                  hi_d   = acc_new[9:0];
                  mode_d = MODE_SUR_BSL;
                end
              end else begin
                mode_d      = MODE_NORMAL;
                push        = 1'b1;
                cmd_o.kind  = CMD_CODE;
                cmd_o.value = {5'd0, acc_new};
              end
            end
          end
        end
        MODE_SUR_BSL: begin
          if (c != ChBsl) begin
            push = 1'b1; cmd_o.kind = CMD_END; cmd_o.err = ERR_SURR; halted_d = 1'b1;
          end else begin
            mode_d = MODE_SUR_U;
          end
        end
        MODE_SUR_U: begin
          if (c != ChU) begin
            push = 1'b1; cmd_o.kind = CMD_END; cmd_o.err = ERR_SURR; halted_d = 1'b1;
          end else begin
            mode_d = MODE_SUR_HEX;
            cnt_d  = '0;
            acc_d  = '0;
          end
        end
        default: begin
          mode_d = MODE_NORMAL;
          if (rem_e != 2'd0) begin
            push = 1'b1;
            if (!cls_ok) begin
              cmd_o.kind = CMD_END; cmd_o.err = ERR_UTF8; halted_d = 1'b1;
            end else begin
              cls_d = CLS_ANY;
              rem_d = rem_e - 2'd1;
            end
          end else if (c == ChQuote) begin
            push = 1'b1; cmd_o.kind = CMD_END; halted_d = 1'b1;
          end else if (c == ChBsl) begin
            mode_d = MODE_ESC;
          end else if (c < 8'h20) begin
            push = 1'b1; cmd_o.kind = CMD_END; cmd_o.err = ERR_CTRL; halted_d = 1'b1;
          end else if (c < 8'h80 || !check_q) begin
            push = 1'b1;
          end else begin
            push = 1'b1;
            if (c >= 8'hC2 && c <= 8'hDF) begin
              rem_d = 2'd1; cls_d = CLS_ANY;
            end else if (c >= 8'hE0 && c <= 8'hEF) begin
              rem_d = 2'd2;
              cls_d = (c == 8'hE0) ? CLS_A0_BF : (c == 8'hED) ? CLS_80_9F : CLS_ANY;
            end else if (c >= 8'hF0 && c <= 8'hF4) begin
              rem_d = 2'd3;
              cls_d = (c == 8'hF0) ? CLS_90_BF : (c == 8'hF4) ? CLS_80_8F : CLS_ANY;
            end else begin
              cmd_o.kind = CMD_END; cmd_o.err = ERR_UTF8; halted_d = 1'b1;
            end
          end
        end
      endcase
    end

    // the restart mark rides on the next command that leaves the front
    restart_d = push ? 1'b0 : restart_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      cls_q     <= CLS_ANY;
      cnt_q     <= '0;
      acc_q     <= '0;
      hi_q      <= '0;
      rem_q     <= '0;
      halted_q  <= 1'b0;
      restart_q <= 1'b0;
      check_q   <= 1'b1;
    end else begin
      if (cfg_i.valid) begin
        check_q <= cfg_i.check_utf8;
      end
      if (fire) begin
        mode_q    <= mode_d;
        cls_q     <= cls_d;
        cnt_q     <= cnt_d;
        acc_q     <= acc_d;
        hi_q      <= hi_d;
        rem_q     <= rem_d;
        halted_q  <= halted_d;
        restart_q <= restart_d;
      end
    end
  end

endmodule

>>> design/jsu_fifo.sv
module jsu_fifo import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o     = cnt_q == FifoCntW'(FifoDepth);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/jsu_back.sv
module jsu_back import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  cmd_t     cmd_i,
  output logic     pop_o,
  jsu_out_if.source out_o
);

  logic               valid_q;
  logic [31:0]        bytes_q, bytes_d;
  logic [2:0]         count_q, count_d;
  logic               last_q;
  logic [2:0]         err_q;
  logic [OutLenW-1:0] slen_q;
  logic [LenBits-1:0] len_q, len_base, len_d;
  logic [LenBits:0]   len_sum;
  logic [20:0]        cp;

  assign pop_o = !empty_i && (!valid_q || out_o.ready);
  assign cp    = cmd_i.value;

  // utf-8 encoding of one command
  always_comb begin
    bytes_d = {24'd0, cp[7:0]};
    count_d = 3'd1;
    unique case (cmd_i.kind)
      CMD_END: begin
        bytes_d = '0;
        count_d = 3'd0;
      end
      CMD_CODE: begin
        if (cp < 21'h80) begin
          bytes_d = {24'd0, cp[7:0]};
          count_d = 3'd1;
        end else if (cp < 21'h800) begin
          bytes_d = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
          count_d = 3'd2;
        end else if (cp < 21'h10000) begin
          bytes_d = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
          count_d = 3'd3;
        end else begin
          bytes_d = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                     5'b11110, cp[20:18]};
          count_d = 3'd4;
        end
      end
      default: begin
        bytes_d = {24'd0, cp[7:0]};
        count_d = 3'd1;
      end
    endcase
  end

  // saturating length count
  always_comb begin
    len_base = cmd_i.restart ? '0 : len_q;
    len_sum  = {1'b0, len_base} + (LenBits + 1)'(count_d);
    len_d    = len_sum[LenBits] ? '1 : len_sum[LenBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      len_q   <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        len_q   <= len_d;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q <= bytes_d;
      count_q <= count_d;
      last_q  <= cmd_i.kind == CMD_END;
      err_q   <= cmd_i.err;
      slen_q  <= OutLenW'(len_d);
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_bytes     = bytes_q;
  assign out_o.out_count     = count_q;
  assign out_o.last          = last_q;
  assign out_o.err_code      = err_q;
  assign out_o.string_length = slen_q;

endmodule

>>> design/json_string_unescape_validate.sv
// json string body decoder
// in_i carries one raw byte of a string body per beat, starting with the
// byte after the opening quote; first_byte marks that byte and clears all
// string state. escapes, including \uXXXX with surrogate pairs, are resolved
// and an escape leaves on out_o as one beat of 1 to 4 utf-8 bytes, any
// raw byte as one beat. the closing quote or the first error gives a beat
// with last set, the error code and the decoded length; later bytes give
// no beat until the next first_byte. cfg_i writes check_utf8 (reset 1),
// taken on any cycle. throughput: one byte per cycle while the queue is not
// full; the front classifies a byte in the cycle it is taken, so a new byte
// may follow every cycle. a byte's command is written into the queue at the
// edge that takes the byte, then into the output register once it is free.
// when out_o stalls, the output register holds its beat, the back stops
// and the 4-entry command queue fills; in_i.ready drops once it is full.
// reset empties the queue and the output register, clears string state
// and restores check_utf8 to 1; in_i is ready right after reset.
module json_string_unescape_validate import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_cfg_if.sink   cfg_i,
  jsu_out_if.source out_o
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic full;

  // queue to back
  logic pop;
  cmd_t head_cmd;
  logic empty;

  // front: byte classification, escape and surrogate tracking, utf-8 checks
  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // short command queue so both sides stall on their own
  jsu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  // back: utf-8 encoding, length count, output register
  jsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
